// File: hdl/crbf_pkg.sv
// Shared constants, codes and controller/datapath types for the cubic root finder.
`timescale 1ns / 1ps

package crbf_pkg;

   localparam int CoefWidth     = 24;
   localparam int RootWidth     = 32;
   localparam int MaxRoots      = 3;
   localparam int RootCntWidth  = 2;
   localparam int DigitWidth    = 16;
   localparam int TermWidth     = 64;
   localparam int QuotWidth     = 62;
   localparam int CsrIdxWidth   = 2;
   localparam int PosWidth      = 8;

   localparam int FracBitsDflt  = 24;
   localparam int ScanMinDflt   = -100;
   localparam int ScanMaxDflt   = 100;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_COEF_CUBIC  = 2'd0,
      CSR_COEF_SQUARE = 2'd1,
      CSR_COEF_LINEAR = 2'd2,
      CSR_COEF_CONST  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      XSEL_LEFT,
      XSEL_RIGHT,
      XSEL_MID
   } xsel_type;

   typedef enum logic [1:0] {
      OUT_DEGEN,
      OUT_NONE,
      OUT_ROOT
   } out_kind_type;

   typedef struct packed {
      logic         scan_init;
      logic         eval_go;
      xsel_type     eval_sel;
      logic         latch_left;
      logic         latch_right;
      logic         bis_init;
      logic         bis_step;
      logic         root_check;
      logic         scan_next;
      logic         out_load;
      out_kind_type out_kind;
   } crbf_cmd_type;

   typedef struct packed {
      logic coef_zero;
      logic eval_done;
      logic straddle;
      logic iter_last;
      logic scan_last;
      logic roots_full;
      logic roots_none;
      logic out_last;
   } crbf_status_type;

endpackage

// File: hdl/crbf_req_if.sv
// Start request channel of the cubic root finder.
`timescale 1ns / 1ps

interface crbf_req_if;
   logic valid;
   logic ready;
   logic start_req;

   modport source (output valid, output start_req, input ready);
   modport sink   (input valid, input start_req, output ready);
endinterface

// File: hdl/crbf_rsp_if.sv
// Result channel of the cubic root finder.
`timescale 1ns / 1ps

interface crbf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] root_value;
   logic               found;
   logic               degenerate;
   logic               last_root;

   modport source (output valid, output root_value, output found, output degenerate,
                   output last_root, input ready);
   modport sink   (input valid, input root_value, input found, input degenerate,
                   input last_root, output ready);
endinterface

// File: hdl/crbf_eval.sv
// Horner evaluator: sign of the cubic at one point, on a shared 64x16 multiplier.
`timescale 1ns / 1ps

module crbf_eval
   import crbf_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDflt
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic signed [FRAC_BITS+8:0]   x,
   input  logic signed [CoefWidth-1:0]   coef_a,
   input  logic signed [CoefWidth-1:0]   coef_b,
   input  logic signed [CoefWidth-1:0]   coef_c,
   input  logic signed [CoefWidth-1:0]   coef_d,
   output logic                          done,
   output logic                          res_neg,
   output logic                          res_zero
);

   localparam int XW = FRAC_BITS + 9;
   localparam int ND = (XW + DigitWidth - 1) / DigitWidth;
   localparam int PW = ND * DigitWidth;
   localparam int AW = TermWidth + PW;
   localparam int DW = (ND > 1) ? $clog2(ND) : 1;

   typedef enum logic [1:0] {E_IDLE, E_MUL, E_ADD} est_type;

   est_type                 st_ff;
   logic [TermWidth-1:0]    tmag_ff;
   logic                    pneg_ff;
   logic                    xneg_ff;
   logic [PW-1:0]           xmag_ff;
   logic [PW-1:0]           xsh_ff;
   logic [AW-1:0]           acc_ff;
   logic [DW-1:0]           dcnt_ff;
   logic [1:0]              hstep_ff;
   logic                    done_ff;
   logic                    neg_ff;
   logic                    zero_ff;

   logic [XW-1:0]              xabs;
   logic [TermWidth-1:0]       amag;
   logic signed [TermWidth-1:0] a64;
   logic [QuotWidth-1:0]       q;
   logic signed [TermWidth-1:0] qs;
   logic signed [TermWidth-1:0] cadd;
   logic signed [TermWidth-1:0] tnew_in;
   logic [AW-1:0]              acc_in;

   always_comb begin
      xabs    = x[XW-1] ? XW'(-x) : XW'(x);
      a64     = TermWidth'(coef_a);
      amag    = a64[TermWidth-1] ? TermWidth'(-a64) : TermWidth'(a64);
      q       = acc_ff[FRAC_BITS+QuotWidth-1:FRAC_BITS];
      qs      = pneg_ff ? -signed'(TermWidth'(q)) : signed'(TermWidth'(q));
      unique case (hstep_ff)
         2'd0:    cadd = TermWidth'(coef_b);
         2'd1:    cadd = TermWidth'(coef_c);
         default: cadd = TermWidth'(coef_d);
      endcase
      tnew_in = qs + cadd;
      acc_in  = (acc_ff << DigitWidth)
              + AW'(tmag_ff * xsh_ff[PW-1 -: DigitWidth]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            E_IDLE: begin
               if (go) begin
                  tmag_ff  <= amag;
                  pneg_ff  <= coef_a[CoefWidth-1] ^ x[XW-1];
                  xneg_ff  <= x[XW-1];
                  xmag_ff  <= PW'(xabs);
                  xsh_ff   <= PW'(xabs);
                  acc_ff   <= '0;
                  dcnt_ff  <= '0;
                  hstep_ff <= 2'd0;
                  st_ff    <= E_MUL;
               end
            end
            E_MUL: begin
               acc_ff  <= acc_in;
               xsh_ff  <= xsh_ff << DigitWidth;
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DW'(ND - 1)) st_ff <= E_ADD;
            end
            E_ADD: begin
               tmag_ff <= tnew_in[TermWidth-1] ? TermWidth'(-tnew_in) : TermWidth'(tnew_in);
               pneg_ff <= tnew_in[TermWidth-1] ^ xneg_ff;
               if (hstep_ff == 2'd2) begin
                  done_ff <= 1'b1;
                  neg_ff  <= tnew_in[TermWidth-1];
                  zero_ff <= (tnew_in == '0);
                  st_ff   <= E_IDLE;
               end else begin
                  hstep_ff <= hstep_ff + 1'b1;
                  xsh_ff   <= xmag_ff;
                  acc_ff   <= '0;
                  dcnt_ff  <= '0;
                  st_ff    <= E_MUL;
               end
            end
            default: st_ff <= E_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign res_neg  = neg_ff;
   assign res_zero = zero_ff;

   a_done_after_add: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(st_ff == E_ADD))
      else $error("evaluator done without final add");

   a_go_only_idle: assert property (@(posedge clock) disable iff (reset)
      (go && st_ff != E_IDLE) |-> 1'b0)
      else $error("evaluator started while busy");

   a_hstep_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff != E_IDLE) |-> (hstep_ff != 2'd3))
      else $error("Horner step out of range");

endmodule

// File: hdl/crbf_datapath.sv
// Datapath: coefficients, scan and bisection bounds, kept roots and result register.
`timescale 1ns / 1ps

module crbf_datapath
   import crbf_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDflt,
   parameter int SCAN_MIN  = ScanMinDflt,
   parameter int SCAN_MAX  = ScanMaxDflt
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CoefWidth-1:0]          csr_wdata,
   input  crbf_cmd_type                  cmd,
   output crbf_status_type               status,
   output logic signed [RootWidth-1:0]   root_value,
   output logic                          found,
   output logic                          degenerate,
   output logic                          last_root
);

   localparam int XW = FRAC_BITS + 9;
   localparam int IW = $clog2(FRAC_BITS);

   logic signed [CoefWidth-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [PosWidth-1:0]  pos_ff;
   logic signed [XW-1:0]        lo_ff, hi_ff, mlast_ff, kept_ff;
   logic                        have_ff;
   logic [IW-1:0]               iter_ff;
   logic                        sl_neg_ff, sl_zero_ff, sr_neg_ff, sr_zero_ff;
   logic                        sb_neg_ff, sb_zero_ff;
   logic [RootCntWidth-1:0]     nroot_ff, oidx_ff;
   logic [RootWidth-1:0]        roots_ff [MaxRoots];
   logic [RootWidth-1:0]        rval_ff;
   logic                        found_ff, degen_ff, last_ff;

   logic signed [XW-1:0]        one;
   logic signed [XW-1:0]        x_left, x_right, x_mid, x_sel;
   logic signed [PosWidth:0]    pos_p1;
   logic signed [XW:0]          rdiff;
   logic [XW:0]                 rmag;
   logic                        far;
   logic signed [TermWidth-1:0] m64;
   logic                        ev_done, ev_neg, ev_zero;
   logic                        take_m;

   always_comb begin
      one     = XW'(1) << FRAC_BITS;
      pos_p1  = {pos_ff[PosWidth-1], pos_ff} + (PosWidth+1)'(1);
      x_left  = XW'(pos_ff) <<< FRAC_BITS;
      x_right = XW'(pos_p1) <<< FRAC_BITS;
      x_mid   = lo_ff + XW'((hi_ff - lo_ff) >>> 1);
      unique case (cmd.eval_sel)
         XSEL_LEFT:  x_sel = x_left;
         XSEL_RIGHT: x_sel = x_right;
         default:    x_sel = x_mid;
      endcase
      rdiff = {mlast_ff[XW-1], mlast_ff} - {kept_ff[XW-1], kept_ff};
      rmag  = rdiff[XW] ? (XW+1)'(-rdiff) : (XW+1)'(rdiff);
      far   = rmag >= {1'b0, one};
      m64   = TermWidth'(mlast_ff);
      // a product of signs <= 0 moves the upper bound
      take_m = sb_zero_ff || ev_zero || (sb_neg_ff != ev_neg);
   end

   crbf_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.eval_go),
      .x        (x_sel),
      .coef_a   (coef_a_ff),
      .coef_b   (coef_b_ff),
      .coef_c   (coef_c_ff),
      .coef_d   (coef_d_ff),
      .done     (ev_done),
      .res_neg  (ev_neg),
      .res_zero (ev_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         coef_d_ff <= '0;
         pos_ff    <= PosWidth'(SCAN_MIN);
         have_ff   <= 1'b0;
         kept_ff   <= '0;
         iter_ff   <= '0;
         nroot_ff  <= '0;
         oidx_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_COEF_CUBIC:  coef_a_ff <= csr_wdata;
               CSR_COEF_SQUARE: coef_b_ff <= csr_wdata;
               CSR_COEF_LINEAR: coef_c_ff <= csr_wdata;
               CSR_COEF_CONST:  coef_d_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.scan_init) begin
            pos_ff   <= PosWidth'(SCAN_MIN);
            have_ff  <= 1'b0;
            kept_ff  <= '0;
            nroot_ff <= '0;
            oidx_ff  <= '0;
         end
         if (cmd.latch_left && ev_done) begin
            sl_neg_ff  <= ev_neg;
            sl_zero_ff <= ev_zero;
         end
         if (cmd.latch_right && ev_done) begin
            sr_neg_ff  <= ev_neg;
            sr_zero_ff <= ev_zero;
         end
         if (cmd.bis_init) begin
            lo_ff      <= x_left;
            hi_ff      <= x_right;
            iter_ff    <= '0;
            sb_neg_ff  <= sl_neg_ff;
            sb_zero_ff <= sl_zero_ff;
         end
         if (cmd.bis_step && ev_done) begin
            mlast_ff <= x_mid;
            iter_ff  <= iter_ff + 1'b1;
            if (take_m) begin
               hi_ff <= x_mid;
            end else begin
               lo_ff      <= x_mid;
               sb_neg_ff  <= ev_neg;
               sb_zero_ff <= ev_zero;
            end
         end
         if (cmd.root_check && (!have_ff || far)) begin
            roots_ff[nroot_ff] <= m64[RootWidth-1:0];
            nroot_ff           <= nroot_ff + 1'b1;
            kept_ff            <= mlast_ff;
            have_ff            <= 1'b1;
         end
         if (cmd.scan_next) begin
            pos_ff     <= pos_p1[PosWidth-1:0];
            sl_neg_ff  <= sr_neg_ff;
            sl_zero_ff <= sr_zero_ff;
         end
         if (cmd.out_load) begin
            unique case (cmd.out_kind)
               OUT_DEGEN: begin
                  rval_ff  <= '0;
                  found_ff <= 1'b0;
                  degen_ff <= 1'b1;
                  last_ff  <= 1'b1;
               end
               OUT_NONE: begin
                  rval_ff  <= '0;
                  found_ff <= 1'b0;
                  degen_ff <= 1'b0;
                  last_ff  <= 1'b1;
               end
               default: begin
                  rval_ff  <= roots_ff[oidx_ff];
                  found_ff <= 1'b1;
                  degen_ff <= 1'b0;
                  last_ff  <= (oidx_ff + 1'b1 == nroot_ff);
                  oidx_ff  <= oidx_ff + 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      status.coef_zero  = (coef_a_ff == '0) && (coef_b_ff == '0)
                       && (coef_c_ff == '0) && (coef_d_ff == '0);
      status.eval_done  = ev_done;
      status.straddle   = sl_zero_ff || sr_zero_ff || (sl_neg_ff != sr_neg_ff);
      status.iter_last  = (iter_ff == IW'(FRAC_BITS - 1));
      status.scan_last  = (pos_ff == PosWidth'(SCAN_MAX));
      status.roots_full = (nroot_ff == RootCntWidth'(MaxRoots));
      status.roots_none = (nroot_ff == '0);
      status.out_last   = last_ff;
   end

   assign root_value = rval_ff;
   assign found      = found_ff;
   assign degenerate = degen_ff;
   assign last_root  = last_ff;

   a_root_cnt: assert property (@(posedge clock) disable iff (reset)
      nroot_ff <= RootCntWidth'(MaxRoots))
      else $error("kept root count overflow");

   a_check_room: assert property (@(posedge clock) disable iff (reset)
      cmd.root_check |-> (nroot_ff < RootCntWidth'(MaxRoots)))
      else $error("root check with full root list");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.bis_step && ev_done) |=> (hi_ff > lo_ff))
      else $error("bisection bounds crossed");

endmodule

// File: hdl/crbf_ctrl.sv
// Controller: sequences scan, bisection, root check and result delivery.
`timescale 1ns / 1ps

module crbf_ctrl
   import crbf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_start,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  crbf_status_type status,
   output crbf_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST_GO,
      S_FIRST_WAIT,
      S_RIGHT_GO,
      S_RIGHT_WAIT,
      S_DECIDE,
      S_BIS_GO,
      S_BIS_WAIT,
      S_CHECK,
      S_NEXT,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.eval_sel = XSEL_MID;
      cmd.out_kind = OUT_ROOT;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_start) begin
               if (status.coef_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_DEGEN;
               end else begin
                  cmd.scan_init = 1'b1;
               end
            end
         end
         S_FIRST_GO: begin
            cmd.eval_go  = 1'b1;
            cmd.eval_sel = XSEL_LEFT;
         end
         S_FIRST_WAIT: cmd.latch_left  = 1'b1;
         S_RIGHT_GO: begin
            cmd.eval_go  = 1'b1;
            cmd.eval_sel = XSEL_RIGHT;
         end
         S_RIGHT_WAIT: cmd.latch_right = 1'b1;
         S_DECIDE:     cmd.bis_init    = status.straddle;
         S_BIS_GO: begin
            cmd.eval_go  = 1'b1;
            cmd.eval_sel = XSEL_MID;
         end
         S_BIS_WAIT:   cmd.bis_step    = 1'b1;
         S_CHECK:      cmd.root_check  = 1'b1;
         S_NEXT: begin
            if (status.roots_full || status.scan_last) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = status.roots_none ? OUT_NONE : OUT_ROOT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_ready && !status.out_last) cmd.out_load = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_start) begin
                  if (status.coef_zero) begin
                     state_ff     <= S_EMIT;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_FIRST_GO;
                  end
               end
            end
            S_FIRST_GO:   state_ff <= S_FIRST_WAIT;
            S_FIRST_WAIT: if (status.eval_done) state_ff <= S_RIGHT_GO;
            S_RIGHT_GO:   state_ff <= S_RIGHT_WAIT;
            S_RIGHT_WAIT: if (status.eval_done) state_ff <= S_DECIDE;
            S_DECIDE:     state_ff <= status.straddle ? S_BIS_GO : S_NEXT;
            S_BIS_GO:     state_ff <= S_BIS_WAIT;
            S_BIS_WAIT: begin
               if (status.eval_done) state_ff <= status.iter_last ? S_CHECK : S_BIS_GO;
            end
            S_CHECK:      state_ff <= S_NEXT;
            S_NEXT: begin
               if (status.roots_full || status.scan_last) begin
                  state_ff     <= S_EMIT;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_RIGHT_GO;
               end
            end
            S_EMIT: begin
               if (rsp_ready && status.out_last) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_valid_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_EMIT))
      else $error("result valid outside delivery");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("request taken while results pending");

   a_emit_loaded: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result shown without payload load");

endmodule

// File: hdl/cubic_root_bisection_finder_core.sv
// Top level of the cubic root finder: controller, datapath and channel hookup.
`timescale 1ns / 1ps

// A start item (start_req = 1) searches a*x^3+b*x^2+c*x+d for real roots over the
// unit intervals SCAN_MIN..SCAN_MAX, bisecting FRAC_BITS times in each interval
// whose end signs differ or touch zero; up to three roots at least 1 apart come
// out in ascending order, the last flagged, or one result with found = 0
// (degenerate = 1 when all coefficients are zero). Each point evaluation feeds
// x, in ND = ceil((FRAC_BITS+9)/16) digits of 16 bits, through the single 64x16
// multiplier of the Horner evaluator. A search costs at most (SCAN_MAX-SCAN_MIN+2)
// evaluations, one per interval end, and FRAC_BITS evaluations per bisected
// interval. A start_req = 0 item or an all-zero polynomial finishes without a
// search.
// Items are taken only while the block is idle: no search running and no result
// pending.
module cubic_root_bisection_finder_core
   import crbf_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDflt,
   parameter int SCAN_MIN  = ScanMinDflt,
   parameter int SCAN_MAX  = ScanMaxDflt
) (
   input  logic                   clock,
   input  logic                   reset,
   crbf_req_if.sink               req,
   crbf_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CoefWidth-1:0]   csr_wdata
);

   crbf_cmd_type    cmd;
   crbf_status_type status;

   crbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_start (req.start_req),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   crbf_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .SCAN_MIN  (SCAN_MIN),
      .SCAN_MAX  (SCAN_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .root_value (rsp.root_value),
      .found      (rsp.found),
      .degenerate (rsp.degenerate),
      .last_root  (rsp.last_root)
   );

endmodule

// File: tb/tb_cubic_root_bisection_finder_core.sv
// Self-checking testbench for the cubic root finder core.
`timescale 1ns / 1ps

module tb_cubic_root_bisection_finder_core;
   import crbf_pkg::*;

   localparam int FracBits  = 24;
   localparam int ScanLo    = -100;
   localparam int ScanHi    = 100;
   localparam int IdleLimit = 500000;
   localparam int Settle    = 4000;

   typedef struct packed {
      logic signed [31:0] root_value;
      logic               found;
      logic               degenerate;
      logic               last_root;
   } root_res_type;

   typedef struct {
      logic         start;
      logic [23:0]  coef [4];
      logic         has_fixed;
      root_res_type fixed;
   } vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CoefWidth-1:0] csr_wdata = '0;

   crbf_req_if req ();
   crbf_rsp_if rsp ();

   cubic_root_bisection_finder_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [63:0] poly [4];
   root_res_type roots_due [$];
   int errors = 0;
   int idle_cycles = 0;
   logic hold_rsp = 1'b0;
   logic stall_pat = 1'b0;
   int stall_mode = 0;

   function automatic logic signed [63:0] trunc_mul(logic signed [63:0] t,
                                                     logic signed [63:0] x);
      logic signed [127:0] p;
      logic [127:0] mag;
      logic [63:0] q;
      p   = 128'(t) * 128'(x);
      mag = p[127] ? -p : p;
      q   = 64'(mag >> FracBits) & 64'h3FFF_FFFF_FFFF_FFFF;
      return p[127] ? -$signed(q) : $signed(q);
   endfunction

   function automatic int poly_sign(logic signed [63:0] x);
      logic signed [63:0] t;
      t = poly[0];
      t = trunc_mul(t, x) + poly[1];
      t = trunc_mul(t, x) + poly[2];
      t = trunc_mul(t, x) + poly[3];
      return t > 0 ? 1 : (t < 0 ? -1 : 0);
   endfunction

   task automatic predict_roots();
      logic signed [63:0] one, l, r, m, kept, diff;
      logic signed [63:0] found_roots [$];
      bit have;
      root_res_type res;
      one = 64'sd1 <<< FracBits;
      have = 0;
      kept = 0;
      if (poly[0] == 0 && poly[1] == 0 && poly[2] == 0 && poly[3] == 0) begin
         res = '{root_value: 0, found: 0, degenerate: 1, last_root: 1};
         roots_due.insert(roots_due.size(), res);
         return;
      end
      for (int p = ScanLo; p <= ScanHi && found_roots.size() < MaxRoots; p++) begin
         l = 64'(p) * one;
         r = l + one;
         m = l;
         if (poly_sign(l) * poly_sign(r) > 0) continue;
         for (int i = 0; i < FracBits; i++) begin
            m = l + ((r - l) >>> 1);
            if (poly_sign(l) * poly_sign(m) <= 0) r = m;
            else l = m;
         end
         diff = m - kept;
         if (diff < 0) diff = -diff;
         if (!have || diff >= one) begin
            kept = m;
            have = 1;
            found_roots.insert(found_roots.size(), m);
         end
      end
      if (found_roots.size() == 0) begin
         res = '{root_value: 0, found: 0, degenerate: 0, last_root: 1};
         roots_due.insert(roots_due.size(), res);
      end
      foreach (found_roots[k]) begin
         res = '{root_value: found_roots[k][31:0], found: 1, degenerate: 0,
                 last_root: k == found_roots.size() - 1};
         roots_due.insert(roots_due.size(), res);
      end
   endtask

   task automatic write_coef(csr_index_type idx, logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      poly[idx] = $signed(val);
      @(posedge clock);
   endtask

   // registers change only once the block has drained
   task automatic load_poly(logic [23:0] c [4]);
      wait (roots_due.size() == 0);
      repeat (Settle) @(posedge clock);
      write_coef(CSR_COEF_CUBIC, c[0]);
      write_coef(CSR_COEF_SQUARE, c[1]);
      write_coef(CSR_COEF_LINEAR, c[2]);
      write_coef(CSR_COEF_CONST, c[3]);
      csr_we <= 1'b0;
   endtask

   task automatic send_start(logic s);
      req.valid     <= 1'b1;
      req.start_req <= s;
      do @(posedge clock); while (!req.ready);
      if (s) predict_roots();
   endtask

   function automatic logic [23:0] q16(int v);
      return 24'(v * 65536);
   endfunction

   function automatic logic [23:0] rnd_coef();
      unique case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return q16($urandom_range(0, 200) - 100);
         2: return 24'($urandom_range(0, 13107200) - 6553600);
         3: return $urandom_range(0, 1) ? 24'd6553600 : 24'(-6553600);
         4: return 24'($urandom_range(0, 64) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   vec_type plan [$];

   task automatic add_row(logic s, int a, int b, int c, int d);
      vec_type v;
      v.start = s;
      v.coef = '{q16(a), q16(b), q16(c), q16(d)};
      v.has_fixed = 0;
      v.fixed = '0;
      plan.insert(plan.size(), v);
   endtask

   initial begin
      logic [23:0] cf [4];
      logic [23:0] last_cf [4];
      vec_type v;
      req.valid     = 1'b0;
      req.start_req = 1'b0;
      poly = '{0, 0, 0, 0};
      last_cf = '{24'd0, 24'd0, 24'd0, 24'd0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // after reset: all-zero polynomial is degenerate
      v.start = 1; v.coef = '{0, 0, 0, 0}; v.has_fixed = 1;
      v.fixed = '{root_value: 0, found: 0, degenerate: 1, last_root: 1};
      plan.insert(plan.size(), v);
      add_row(0, 0, 0, 0, 0);
      v.coef = '{0, 0, 0, q16(1)};
      v.fixed = '{root_value: 0, found: 0, degenerate: 0, last_root: 1};
      plan.insert(plan.size(), v);
      add_row(1, 0, 0, 1, 0);
      add_row(1, 1, 0, -1, 0);
      add_row(1, 1, -2, -1, 2);
      add_row(1, 1, 0, 0, 0);
      add_row(1, 0, 1, 0, -100);
      add_row(1, 100, 0, 0, 100);
      add_row(1, -100, -100, -100, -100);
      add_row(1, 0, 0, -1, 100);
      add_row(1, 0, 0, 0, -100);
      add_row(0, 0, 0, 0, -100);
      v.start = 1; v.has_fixed = 0;
      v.coef = '{24'd1, 24'd0, 24'd0, 24'd0};
      plan.insert(plan.size(), v);
      v.coef = '{24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF};
      plan.insert(plan.size(), v);
      v.coef = '{24'h7FFFFF, 24'h000001, 24'hFFFFFF, 24'h800000};
      plan.insert(plan.size(), v);

      foreach (plan[i]) begin
         if (plan[i].coef != last_cf) begin
            req.valid <= 1'b0;
            load_poly(plan[i].coef);
            last_cf = plan[i].coef;
         end
         if (plan[i].has_fixed) begin
            send_start(1'b1);
            if (roots_due[$] !== plan[i].fixed) begin
               $error("table row %0d: predicted %p, table %p", i, roots_due[$],
                      plan[i].fixed);
               errors++;
            end
         end else begin
            send_start(plan[i].start);
         end
      end

      // long receiver hold while starts keep coming
      stall_mode = 1;
      repeat (4) send_start(1'b1);
      req.valid <= 1'b0;
      wait (roots_due.size() == 0);
      stall_mode = 0;

      for (int n = 0; n < 290; ) begin
         if ($urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            for (int k = 0; k < 4; k++) cf[k] = rnd_coef();
            load_poly(cf);
         end
         for (int b = $urandom_range(1, 6); b > 0 && n < 290; b--, n++)
            send_start($urandom_range(0, 7) != 0);
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid <= 1'b0;
      wait (roots_due.size() == 0);
      repeat (Settle) @(posedge clock);
      if (errors == 0)
         $display("tb_cubic_root_bisection_finder_core OK");
      else
         $display("tb_cubic_root_bisection_finder_core NOT OK");
      $finish;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_mode == 1 && !hold_rsp) begin
            hold_rsp <= 1'b1;
            rsp.ready <= 1'b0;
            repeat (20000) @(posedge clock);
            hold_rsp <= 1'b0;
            stall_mode = 2;
         end else begin
            stall_pat <= ~stall_pat;
            rsp.ready <= ($urandom_range(0, 3) != 0) || stall_pat;
         end
      end
   end

   always @(posedge clock) begin
      root_res_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.root_value, rsp.found, rsp.degenerate, rsp.last_root};
         if (roots_due.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
         end else begin
            want = roots_due.pop_front();
            if (got.root_value !== want.root_value) begin
               $error("root_value: expected %0d, got %0d", want.root_value,
                      got.root_value);
               errors++;
            end
            if (got.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, got.found);
               errors++;
            end
            if (got.degenerate !== want.degenerate) begin
               $error("degenerate: expected %0b, got %0b", want.degenerate,
                      got.degenerate);
               errors++;
            end
            if (got.last_root !== want.last_root) begin
               $error("last_root: expected %0b, got %0b", want.last_root,
                      got.last_root);
               errors++;
            end
         end
      end
   end

   // watchdog: stops the run when no item moves for too long
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("tb_cubic_root_bisection_finder_core NOT OK");
         $finish;
      end
   end

endmodule
